[src/ldl_decomposition_top_macros.svh]
// assertion macros for the ldl block
`ifndef LDL_DECOMPOSITION_TOP_MACROS_SVH
`define LDL_DECOMPOSITION_TOP_MACROS_SVH
// implication checked every cycle outside reset
`define LDL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication outside reset
`define LDL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/ldl_pkg.sv]
// ----------------------------------------------------------------------------
// ldl_pkg
// shared types, constants and arithmetic helpers of the ldl block
// ----------------------------------------------------------------------------
package ldl_pkg;
  localparam int MaxDim   = 8;
  localparam int FracBits = 16;
  localparam int IdxW     = $clog2(MaxDim);
  localparam int AddrW    = 2 * IdxW;
  localparam int DimW     = $clog2(MaxDim + 1);
  localparam logic signed [31:0] QOne = 32'sd1 <<< FracBits;
  localparam logic signed [31:0] SMax = 32'sh7fffffff;
  localparam logic signed [31:0] SMin = 32'sh80000000;

  typedef enum logic [3:0] {
    ST_LOAD, ST_DIAG_INIT, ST_OFF_INIT, ST_RD_A, ST_RD_B, ST_MUL1, ST_RND1, ST_MUL2,
    ST_RND2, ST_SUB, ST_DIV_START, ST_DIV_WAIT, ST_EMIT_RD, ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic          ld_acc;     // acc <= matrix read data
    logic          rd_mat;     // read matrix at (i,j)
    logic          rd_l_ik;    // read lower at (i,k)
    logic          rd_l_jk;    // read lower at (j,k)
    logic          mul1;       // prod <= qmul(lik, ljk)
    logic          mul2;       // prod <= qmul(prod, d[k])
    logic          sub;        // acc <= acc - prod
    logic          wr_pivot;   // d[j] <= acc
    logic          div_start;
    logic          wr_l_div;   // lower[i][j] <= quotient
    logic          wr_l_one;   // lower[j][j] <= one
    logic          rd_emit;    // read lower at (i,j) for output
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
    logic [IdxW-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return SMax;
    if (v < -66'sd2147483648) return SMin;
    return v[31:0];
  endfunction

  // rounding: floor((p + half) >> frac) equals the model's two cases
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [65:0] t;
    t = (66'(p) + (66'sd1 <<< (FracBits - 1))) >>> FracBits;
    return sat32(t);
  endfunction
endpackage

[src/ldl_decomposition_top.sv]
// ----------------------------------------------------------------------------
// ldl_decomposition_top
// fixed-point ldl-transpose factorization of a symmetric matrix
// ----------------------------------------------------------------------------
// Usage: elements enter on the in_ channel, one transfer per cycle while
// loading; each is stored at (row, col). The element with in_elem_last high
// starts the factorization of the leading cfg size (written by cfg_wr_en, reset
// 8; the user must write it only while idle, which the block does not enforce).
// During factorization and output in_stall is high. Each pivot takes a matrix
// read, its inner terms and a pivot write; each inner term takes two reads of
// the lower store's single read port, two multiplies each followed by a
// rounding step, and one subtract. Each off-diagonal entry takes a matrix read,
// its inner terms, a divider start and a wait on the bit-serial divider, which
// finishes at once when the pivot is zero. Results follow column by column, row
// j..n-1, each a lower store read and then the output; out_stall holds the
// current item stable. After the final item the block returns to loading.
// Reset returns to loading, clears zero-pivot flags and sets size to 8.
// ----------------------------------------------------------------------------
`include "ldl_decomposition_top_macros.svh"
module ldl_decomposition_top import ldl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_elem_row,
  input  logic [2:0]         in_elem_col,
  input  logic signed [31:0] in_elem_value,
  input  logic               in_elem_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_row,
  output logic [2:0]         out_col,
  output logic signed [31:0] out_l_value,
  output logic signed [31:0] out_d_value,
  output logic               out_pivot_zero,
  output logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data
);
  logic [3:0]      size_r;
  logic [DimW-1:0] dim;
  cmd_t            cmd;
  sts_t            sts;
  logic            loading, emit_valid, emit_last, in_xfer;
  logic signed [31:0] l_rd, d_rd;
  logic            pz_rd;

  // size register and clamp
  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= 4'd8;
    else if (cfg_wr_en) size_r <= cfg_wr_data;
  end
  assign dim = (size_r == 4'd0) ? DimW'(1) :
               (size_r > 4'(MaxDim)) ? DimW'(MaxDim) : DimW'(size_r);

  assign in_stall = !loading;
  assign in_xfer  = in_valid && loading;

  ldl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(in_xfer && in_elem_last), .dim(dim),
    .sts(sts), .out_stall(out_stall), .cmd(cmd), .loading(loading),
    .emit_valid(emit_valid), .emit_last(emit_last)
  );

  ldl_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_wr(in_xfer), .in_row(in_elem_row),
    .in_col(in_elem_col), .in_value(in_elem_value), .cmd(cmd), .sts(sts),
    .l_rd(l_rd), .d_rd(d_rd), .pz_rd(pz_rd)
  );

  // result outputs
  assign out_valid      = emit_valid;
  assign out_row        = cmd.i;
  assign out_col        = cmd.j;
  assign out_l_value    = l_rd;
  assign out_d_value    = (cmd.i == cmd.j) ? d_rd : 32'sd0;
  assign out_pivot_zero = pz_rd;
  assign out_last       = emit_last;

  `LDL_ASSERT_IMP(a_no_out_while_loading, loading, !out_valid, "result while loading")
  `LDL_ASSERT_NXT(a_stall_holds_row, out_valid && out_stall, out_valid && $stable(out_row) && $stable(out_col), "stalled result moved")
  `LDL_ASSERT_IMP(a_last_is_diag, out_valid && out_last, out_row == out_col, "last item off diagonal")
endmodule

[src/ldl_div.sv]
// ----------------------------------------------------------------------------
// ldl_div
// restoring divider, one quotient bit per cycle, rounded and saturated
// ----------------------------------------------------------------------------
module ldl_div import ldl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  localparam int NW = 32 + FracBits;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] n_r, n_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   d_r, d_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic signed [31:0] quo_r, quo_nxt;
  logic [33:0]   trial;
  logic [NW:0]   qr;
  logic signed [65:0] sq;

  // shift-subtract step and final rounding
  always_comb begin
    n_nxt = n_r; rem_nxt = rem_r; d_nxt = d_r; q_nxt = q_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0; quo_nxt = quo_r;
    trial = '0; qr = '0; sq = '0;
    if (start) begin
      n_nxt = NW'(num[31] ? 33'(-34'(num)) : 33'(num)) << FracBits;
      d_nxt = den[31] ? 32'(-33'(den)) : 32'(den);
      neg_nxt = num[31] ^ den[31];
      rem_nxt = '0; q_nxt = '0; cnt_nxt = CW'(NW);
      if (den == 32'sd0) begin
        quo_nxt = num[31] ? SMin : SMax;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        trial = {rem_r, n_r[NW-1]} - {2'b00, d_r};
        if (!trial[33]) begin
          rem_nxt = trial[32:0];
          q_nxt = {q_r[NW-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], n_r[NW-1]};
          q_nxt = {q_r[NW-2:0], 1'b0};
        end
        n_nxt = n_r << 1;
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        // round half away: remainder*2 >= d
        qr = {1'b0, q_r} + ((({rem_r, 1'b0}) >= {1'b0, d_r}) ? 1'b1 : 1'b0);
        sq = neg_r ? -66'(qr) : 66'(qr);
        quo_nxt = sat32(sq);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt; rem_r <= rem_nxt; d_r <= d_nxt; q_r <= q_nxt;
    neg_r <= neg_nxt; quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

[src/ldl_datapath.sv]
// ----------------------------------------------------------------------------
// ldl_datapath
// stores, multiply-subtract accumulator and divider of the ldl block
// ----------------------------------------------------------------------------
module ldl_datapath import ldl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_wr,
  input  logic [IdxW-1:0]    in_row,
  input  logic [IdxW-1:0]    in_col,
  input  logic signed [31:0] in_value,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic signed [31:0] l_rd,
  output logic signed [31:0] d_rd,
  output logic               pz_rd
);
  logic signed [31:0] mat_mem [MaxDim*MaxDim];
  logic signed [31:0] low_mem [MaxDim*MaxDim];
  logic signed [31:0] piv_mem [MaxDim];
  logic [MaxDim-1:0]  zflag_r;
  logic signed [31:0] mat_q_r, la_r, lb_r, acc_r, prod_r, quo;
  logic signed [31:0] acc_now;
  logic signed [31:0] d_emit_r;
  logic signed [63:0] m1_r;
  logic               m1v_r, m2v_r;
  logic               div_done;

  // matrix store: load port and one read port
  always_ff @(posedge clk) begin
    if (in_wr) mat_mem[{in_row, in_col}] <= in_value;
    if (cmd.rd_mat) mat_q_r <= mat_mem[{cmd.i, cmd.j}];
  end

  // lower store: one write, one read port
  always_ff @(posedge clk) begin
    if (cmd.wr_l_div) low_mem[{cmd.i, cmd.j}] <= quo;
    else if (cmd.wr_l_one) low_mem[{cmd.j, cmd.j}] <= QOne;
    if (cmd.rd_l_ik) la_r <= low_mem[{cmd.i, cmd.k}];
    else if (cmd.rd_l_jk) lb_r <= low_mem[{cmd.j, cmd.k}];
    else if (cmd.rd_emit) la_r <= low_mem[{cmd.i, cmd.j}];
  end

  // pivot value, taken straight from the matrix when the column has no terms
  assign acc_now = cmd.ld_acc ? mat_q_r : acc_r;

  // pivot store
  always_ff @(posedge clk) begin
    if (cmd.wr_pivot) piv_mem[cmd.j] <= acc_now;
    if (cmd.rd_emit) d_emit_r <= piv_mem[cmd.j];
  end

  // zero pivot flag per column, written with each pivot
  always_ff @(posedge clk) begin
    if (!rst_n) zflag_r <= '0;
    else if (cmd.wr_pivot)
      zflag_r[cmd.j] <= (acc_now == 32'sd0);
  end

  // two-step product, rounded in the cycle after each multiply
  always_ff @(posedge clk) begin
    if (cmd.mul1) m1_r <= 64'(la_r) * 64'(lb_r);
    m1v_r <= cmd.mul1;
    if (m1v_r) prod_r <= qround(m1_r);
    if (cmd.mul2) m1_r <= 64'(prod_r) * 64'(piv_mem[cmd.k]);
    m2v_r <= cmd.mul2;
    if (m2v_r) prod_r <= qround(m1_r);
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (cmd.ld_acc) acc_r <= mat_q_r;
    else if (cmd.sub) acc_r <= sat32(66'(acc_r) - 66'(prod_r));
  end

  ldl_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(acc_r), .den(piv_mem[cmd.j]), .done(div_done), .quo(quo)
  );

  assign sts.div_done = div_done;
  assign l_rd  = la_r;
  assign d_rd  = d_emit_r;
  assign pz_rd = zflag_r[cmd.j];
endmodule

[src/ldl_ctrl.sv]
// ----------------------------------------------------------------------------
// ldl_ctrl
// sequencer over columns, rows and inner terms of the factorization
// ----------------------------------------------------------------------------
module ldl_ctrl import ldl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DimW-1:0] dim,
  input  sts_t            sts,
  input  logic            out_stall,
  output cmd_t            cmd,
  output logic            loading,
  output logic            emit_valid,
  output logic            emit_last
);
  state_t state_r, state_nxt;
  logic [IdxW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IdxW-1:0] nm1;
  logic            diag_r, diag_nxt;

  assign nm1 = IdxW'(dim - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; i_r <= '0; j_r <= '0; k_r <= '0; diag_r <= 1'b0;
    end else begin
      state_r <= state_nxt; i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
      diag_r <= diag_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r; i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; diag_nxt = diag_r;
    cmd = '0;
    cmd.i = i_r; cmd.j = j_r; cmd.k = k_r;
    loading = 1'b0; emit_valid = 1'b0; emit_last = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        loading = 1'b1;
        if (start) begin
          j_nxt = '0; i_nxt = '0; k_nxt = '0; diag_nxt = 1'b1;
          state_nxt = ST_DIAG_INIT;
        end
      end
      ST_DIAG_INIT, ST_OFF_INIT: begin
        cmd.rd_mat = 1'b1;
        k_nxt = '0;
        state_nxt = ST_RD_A;
      end
      ST_RD_A: begin
        cmd.ld_acc = (k_r == '0);
        if (k_r == j_r) begin
          if (diag_r) begin
            cmd.wr_pivot = 1'b1;
            state_nxt = (j_r == nm1) ? ST_EMIT_RD : ST_OFF_INIT;
            cmd.wr_l_one = 1'b1;
            if (j_r == nm1) begin
              i_nxt = '0; j_nxt = '0;
            end else begin
              i_nxt = j_r + 1'b1; diag_nxt = 1'b0;
            end
          end else begin
            state_nxt = ST_DIV_START;
          end
        end else begin
          cmd.rd_l_ik = 1'b1;
          state_nxt = ST_RD_B;
        end
      end
      ST_RD_B: begin
        cmd.rd_l_jk = 1'b1;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = ST_RND1;
      end
      ST_RND1: begin
        state_nxt = ST_MUL2;   // first product rounded this cycle
      end
      ST_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = ST_RND2;
      end
      ST_RND2: begin
        state_nxt = ST_SUB;    // second product rounded this cycle
      end
      ST_SUB: begin
        cmd.sub = 1'b1;
        k_nxt = k_r + 1'b1;
        state_nxt = ST_RD_A;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.wr_l_div = 1'b1;
          if (i_r == nm1) begin
            j_nxt = j_r + 1'b1; i_nxt = j_r + 1'b1; diag_nxt = 1'b1;
            state_nxt = ST_DIAG_INIT;
          end else begin
            i_nxt = i_r + 1'b1;
            state_nxt = ST_OFF_INIT;
          end
        end
      end
      ST_EMIT_RD: begin
        cmd.rd_emit = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        emit_valid = 1'b1;
        emit_last = (i_r == nm1) && (j_r == nm1);
        if (!out_stall) begin
          if (emit_last) begin
            state_nxt = ST_LOAD;
          end else if (i_r == nm1) begin
            j_nxt = j_r + 1'b1; i_nxt = j_r + 1'b1; state_nxt = ST_EMIT_RD;
          end else begin
            i_nxt = i_r + 1'b1; state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fixed-point ldl factorization block
// ----------------------------------------------------------------------------
// Loads symmetric matrices of assorted sizes and value styles (extremes,
// zero pivots, well-conditioned and fully random), predicts every L and D
// entry with its own fixed-point factorization and checks each output
// transfer in order. The sender works in bursts and the receiver stalls on
// a pattern of its own.
// ----------------------------------------------------------------------------
module tb_top;
  import ldl_pkg::*;

  localparam int IdleLimit  = 200000;
  localparam int ItemTarget = 160;

  typedef struct {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] l_val;
    logic signed [31:0] d_val;
    logic               pz;
    logic               last;
  } ldl_entry_t;

  // ------------------------------------------------------------------------
  // scoreboard: fixed-point factorization and queue of pending entries
  // ------------------------------------------------------------------------
  class LdlScoreboard;
    logic signed [31:0] a_mat [MaxDim*MaxDim];
    logic signed [31:0] l_mat [MaxDim*MaxDim];
    logic signed [31:0] piv [MaxDim];
    logic [3:0]         dim_reg;
    ldl_entry_t         pending_q [$];
    int                 mismatches;

    function void clear();
      foreach (a_mat[x]) begin
        a_mat[x] = '0;
        l_mat[x] = '0;
      end
      foreach (piv[x]) piv[x] = '0;
      dim_reg = 4'd8;
      mismatches = 0;
    endfunction

    function logic signed [31:0] clamp32(logic signed [65:0] v);
      if (v > 66'sd2147483647) return SMax;
      if (v < -66'sd2147483648) return SMin;
      return v[31:0];
    endfunction

    // exact product, round half up, saturate
    function logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [65:0] ea;
      logic signed [65:0] eb;
      logic signed [65:0] p;
      ea = a;
      eb = b;
      p = ea * eb + (66'sd1 <<< (FracBits - 1));
      return clamp32(p >>> FracBits);
    endfunction

    function logic signed [31:0] fx_sub(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [65:0] ea;
      logic signed [65:0] eb;
      ea = a;
      eb = b;
      return clamp32(ea - eb);
    endfunction

    // magnitude division rounded half away from zero
    function logic signed [31:0] fx_div(logic signed [31:0] num, logic signed [31:0] den);
      logic [63:0]        n;
      logic [63:0]        d;
      logic [63:0]        q;
      logic signed [65:0] sq;
      logic               neg;
      if (den == 0) return (num >= 0) ? SMax : SMin;
      n = (num < 0) ? 64'(-66'(num)) : 64'(num);
      d = (den < 0) ? 64'(-66'(den)) : 64'(den);
      neg = (num < 0) != (den < 0);
      q = ((n << FracBits) + d / 2) / d;
      if (q > (64'd1 << 33)) q = 64'd1 << 33;
      sq = $signed({2'b00, q});
      return clamp32(neg ? -sq : sq);
    endfunction

    function void set_dim(logic [3:0] v);
      dim_reg = v;
    endfunction

    function void note_element(logic [2:0] r, logic [2:0] c, logic signed [31:0] v,
                               logic last);
      int                 n;
      logic [7:0]         zflags;
      logic signed [31:0] acc;
      logic signed [31:0] t;
      ldl_entry_t         e;
      a_mat[r*MaxDim + c] = v;
      if (!last) return;
      n = (dim_reg == 0) ? 1 : ((dim_reg > MaxDim) ? MaxDim : int'(dim_reg));
      zflags = '0;
      for (int j = 0; j < n; j++) begin
        acc = a_mat[j*MaxDim + j];
        for (int k = 0; k < j; k++) begin
          t = fx_mul(fx_mul(l_mat[j*MaxDim + k], l_mat[j*MaxDim + k]), piv[k]);
          acc = fx_sub(acc, t);
        end
        piv[j] = acc;
        if (acc == 0) zflags[j] = 1'b1;
        for (int i = j + 1; i < n; i++) begin
          t = a_mat[i*MaxDim + j];
          for (int k = 0; k < j; k++)
            t = fx_sub(t, fx_mul(fx_mul(l_mat[i*MaxDim + k], l_mat[j*MaxDim + k]),
                                 piv[k]));
          l_mat[i*MaxDim + j] = fx_div(t, piv[j]);
        end
        l_mat[j*MaxDim + j] = QOne;
      end
      // emission order: column by column, diagonal first
      for (int j = 0; j < n; j++) begin
        for (int i = j; i < n; i++) begin
          e.row   = 3'(i);
          e.col   = 3'(j);
          e.l_val = l_mat[i*MaxDim + j];
          e.d_val = (i == j) ? piv[j] : '0;
          e.pz    = zflags[j];
          e.last  = (i == n - 1) && (j == n - 1);
          pending_q.push_back(e);
        end
      end
    endfunction

    function void check_entry(ldl_entry_t got);
      ldl_entry_t w;
      if (pending_q.size() == 0) begin
        $error("unexpected output transfer row %0d col %0d", got.row, got.col);
        mismatches++;
        return;
      end
      w = pending_q.pop_front();
      if (got.row !== w.row) begin
        $error("out_row expected %0d actual %0d", w.row, got.row);
        mismatches++;
      end
      if (got.col !== w.col) begin
        $error("out_col expected %0d actual %0d", w.col, got.col);
        mismatches++;
      end
      if (got.l_val !== w.l_val) begin
        $error("out_l_value expected %h actual %h", w.l_val, got.l_val);
        mismatches++;
      end
      if (got.d_val !== w.d_val) begin
        $error("out_d_value expected %h actual %h", w.d_val, got.d_val);
        mismatches++;
      end
      if (got.pz !== w.pz) begin
        $error("out_pivot_zero expected %0b actual %0b", w.pz, got.pz);
        mismatches++;
      end
      if (got.last !== w.last) begin
        $error("out_last expected %0b actual %0b", w.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_elem_row;
  logic [2:0]         in_elem_col;
  logic signed [31:0] in_elem_value;
  logic               in_elem_last;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_row;
  logic [2:0]         out_col;
  logic signed [31:0] out_l_value;
  logic signed [31:0] out_d_value;
  logic               out_pivot_zero;
  logic               out_last;
  logic               cfg_wr_en;
  logic [3:0]         cfg_wr_data;

  LdlScoreboard sb;
  int           items_sent;
  int           burst_left;
  int           idle_cycles;
  int           stall_mode;
  int           stall_count;
  ldl_entry_t   seen;

  ldl_decomposition_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_elem_row   (in_elem_row),
    .in_elem_col   (in_elem_col),
    .in_elem_value (in_elem_value),
    .in_elem_last  (in_elem_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_l_value   (out_l_value),
    .out_d_value   (out_d_value),
    .out_pivot_zero(out_pivot_zero),
    .out_last      (out_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver stall pattern; the mode is redrawn each time a countdown runs out
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode  <= $urandom_range(0, 2);
      stall_count <= 64;
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // output transfer check; signals are settled mid-cycle
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.row   = out_row;
      seen.col   = out_col;
      seen.l_val = out_l_value;
      seen.d_val = out_d_value;
      seen.pz    = out_pivot_zero;
      seen.last  = out_last;
      sb.check_entry(seen);
    end
  end

  // watchdog on cycles without any transfer
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL ldl_decomposition_top");
        $finish;
      end
    end
  end

  // one input transfer, with burst and gap handling
  task automatic send_element(logic [2:0] r, logic [2:0] c, logic signed [31:0] v,
                              logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid      <= 1'b1;
    in_elem_row   <= r;
    in_elem_col   <= c;
    in_elem_value <= v;
    in_elem_last  <= last;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    sb.note_element(r, c, v, last);
    items_sent++;
    burst_left--;
    @(posedge clk);
  endtask

  // wait for all pending entries, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_dim(logic [3:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_dim(v);
  endtask

  // value styles: 0 full random, 1 well conditioned, 2 zero, 3 extremes
  function automatic logic signed [31:0] pick_value(int style, bit diag);
    case (style)
      0: return $urandom;
      1: begin
        if (diag) return {12'd0, 4'($urandom_range(2, 9)), 16'($urandom)};
        return $signed(32'($urandom_range(0, 32'h0001_ffff))) - 32'sh0001_0000;
      end
      2: return '0;
      default: return $urandom_range(0, 1) ? SMax : SMin;
    endcase
  endfunction

  // full lower triangle in random order, optional noise first, last flagged
  task automatic send_matrix(int n, int style, int noise);
    logic [5:0] cells [$];
    logic [5:0] tmp;
    int         sel;
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= r; c++) cells.push_back(6'({3'(r), 3'(c)}));
    for (int x = cells.size() - 1; x > 0; x--) begin
      sel = $urandom_range(0, x);
      tmp = cells[x];
      cells[x] = cells[sel];
      cells[sel] = tmp;
    end
    repeat (noise) send_element(3'($urandom), 3'($urandom), $urandom, 1'b0);
    for (int x = 0; x < cells.size(); x++)
      send_element(cells[x][5:3], cells[x][2:0],
                   pick_value(style, cells[x][5:3] == cells[x][2:0]),
                   x == cells.size() - 1);
  endtask

  initial begin
    int         dim;
    logic [3:0] cfg_val;
    int         roll;
    sb = new();
    sb.clear();
    items_sent    = 0;
    burst_left    = 0;
    idle_cycles   = 0;
    stall_mode    = 0;
    stall_count   = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_elem_row   = '0;
    in_elem_col   = '0;
    in_elem_value = '0;
    in_elem_last  = 1'b0;
    out_stall     = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: size one, size zero, zero pivots, extremes, oversize register
    write_dim(4'd1);
    send_matrix(1, 3, 0);
    drain();
    write_dim(4'd0);
    send_matrix(1, 2, 1);
    drain();
    write_dim(4'd2);
    send_matrix(2, 2, 0);
    drain();
    write_dim(4'd3);
    send_matrix(3, 3, 0);
    send_matrix(3, 1, 2);
    drain();
    write_dim(4'd15);
    send_matrix(MaxDim, 1, 0);
    drain();

    // random: mostly small sizes, occasional full size
    dim = MaxDim;
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 2) == 0 || dim == MaxDim) begin
        drain();
        roll = $urandom_range(0, 15);
        if (roll < 12) cfg_val = 4'($urandom_range(1, 4));
        else if (roll < 14) cfg_val = 4'($urandom_range(5, 8));
        else if (roll == 14) cfg_val = 4'd0;
        else cfg_val = 4'($urandom_range(9, 15));
        write_dim(cfg_val);
        dim = (cfg_val == 0) ? 1 : ((cfg_val > MaxDim) ? MaxDim : int'(cfg_val));
      end
      roll = $urandom_range(0, 9);
      send_matrix(dim, (roll < 5) ? 1 : (roll < 8) ? 0 : (roll == 8) ? 2 : 3,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
    end

    drain();
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("PASS ldl_decomposition_top");
    end else begin
      $display("FAIL ldl_decomposition_top");
    end
    $finish;
  end
endmodule
